// ===== hdl/fip_pkg.sv =====
// ----------------------------------------------------------------------------
// fip_pkg
// Shared widths, codes and constants of the frame interval pacer.
// ----------------------------------------------------------------------------
package fip_pkg;

  // field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SEC_W    = 32;
  localparam int unsigned USEC_W   = 20;
  localparam int unsigned FPS_W    = 10;
  localparam int unsigned WAIT_W   = 10;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_START    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PREPARE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd2;

  // time constants
  localparam logic [FPS_W-1:0]  MS_PER_SEC   = 10'd1000;
  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [SEC_W-1:0]  MAX_MISSED   = 32'd2;
  localparam logic [WAIT_W-1:0] WAIT_MAX     = 10'd1000;
  localparam logic [FPS_W-1:0]  FPS_RESET    = 10'd60;

  // serial multiplier digit width
  localparam int unsigned DIGIT_W = 2;

endpackage

// ===== hdl/fip_in_if.sv =====
// ----------------------------------------------------------------------------
// fip_in_if
// Input channel of the frame interval pacer: valid/ready plus one action word.
// ----------------------------------------------------------------------------
interface fip_in_if import fip_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SEC_W-1:0]    now_sec;
  logic [USEC_W-1:0]   now_usec;
  logic                handler_ok;

  modport source (output valid, action, now_sec, now_usec, handler_ok, input ready);
  modport sink   (input valid, action, now_sec, now_usec, handler_ok, output ready);

endinterface

// ===== hdl/fip_out_if.sv =====
// ----------------------------------------------------------------------------
// fip_out_if
// Result channel of the frame interval pacer: valid/ready plus one result word.
// ----------------------------------------------------------------------------
interface fip_out_if import fip_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              frame_due;
  logic [WAIT_W-1:0] wait_ms;

  modport source (output valid, frame_due, wait_ms, input ready);
  modport sink   (input valid, frame_due, wait_ms, output ready);

endinterface

// ===== hdl/frame_interval_pacer.sv =====
// Start, dispatch and unused codes go straight to the done state; a prepare runs the
// bit-serial divider (one quotient bit a cycle) and the radix-4 serial multiplier (two
// multiplier bits a cycle), with further passes on a rebase or when a wait is reported.
// Throughput: one word at a time; the next is taken while the last result waits.
// Reset: asynchronous, clears start time and frame count, rate returns to 60 fps.
// ----------------------------------------------------------------------------
// frame_interval_pacer
// Frame pacing timer: tracks interval start and frame count, works out elapsed
// milliseconds, due frame number and wait time with shared serial arithmetic.
// ----------------------------------------------------------------------------
module frame_interval_pacer import fip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [FPS_W-1:0] cfg_wdata_i,
  fip_in_if.sink           in_i,
  fip_out_if.source        out_o
);

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DUS_DV = 4'd1;
  localparam logic [3:0] ST_EL_MUL = 4'd2;
  localparam logic [3:0] ST_FN_MUL = 4'd3;
  localparam logic [3:0] ST_FN_DV  = 4'd4;
  localparam logic [3:0] ST_FT_DV  = 4'd5;
  localparam logic [3:0] ST_SH_MUL = 4'd6;
  localparam logic [3:0] ST_TG_MUL = 4'd7;
  localparam logic [3:0] ST_TG_DV  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  // step counts of the serial units
  localparam int unsigned FT_W      = FPS_W + 1;
  localparam logic [5:0]  DIV_STEPS = 6'(SEC_W);
  localparam logic [5:0]  DUS_STEPS = 6'(USEC_W);
  localparam logic [5:0]  FT_STEPS  = 6'(FT_W);
  localparam logic [5:0]  MUL_STEPS = 6'(FPS_W / DIGIT_W);

  logic [3:0]        state_q;
  logic [5:0]        cnt_q;
  logic [FPS_W-1:0]  fps_q;
  logic [SEC_W-1:0]  start_sec_q;
  logic [USEC_W-1:0] start_usec_q;
  logic [SEC_W-1:0]  frames_q;
  logic [SEC_W-1:0]  sec_q;
  logic [USEC_W-1:0] usec_q;
  logic              neg_q;
  logic [SEC_W-1:0]  el_q;
  logic              res_due_q;
  logic [WAIT_W-1:0] res_wait_q;
  logic              out_valid_q;
  logic              out_due_q;
  logic [WAIT_W-1:0] out_wait_q;

  // divider: dividend/quotient shift register, remainder, divisor
  logic [SEC_W-1:0]  dv_q;
  logic [FPS_W-1:0]  rem_q;
  logic [FPS_W-1:0]  dvsr_q;
  // multiplier: accumulator, shifted multiplicand, multiplier digits
  logic [SEC_W-1:0]  acc_q;
  logic [SEC_W-1:0]  mcand_q;
  logic [FPS_W-1:0]  mplr_q;

  logic [FPS_W-1:0]  rate;
  logic              in_acc;
  logic              out_free;
  logic              out_load;

  // effective rate, zero acts as one
  assign rate = (fps_q == '0) ? FPS_W'(1) : fps_q;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign in_acc          = in_i.valid && (state_q == ST_IDLE);
  assign out_free        = !out_valid_q || out_o.ready;
  assign out_load        = (cnt_q == '0) && (state_q == ST_DONE) && out_free;
  assign out_o.valid     = out_valid_q;
  assign out_o.frame_due = out_due_q;
  assign out_o.wait_ms   = out_wait_q;

  // restoring divider step
  logic [FPS_W:0]   rem_sh;
  logic             q_bit;
  logic [FPS_W:0]   rem_sub;
  logic [FPS_W-1:0] rem_nx;

  assign rem_sh  = {rem_q, dv_q[SEC_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, dvsr_q});
  assign rem_sub = rem_sh - {1'b0, dvsr_q};
  assign rem_nx  = q_bit ? rem_sub[FPS_W-1:0] : rem_sh[FPS_W-1:0];

  // radix-4 multiplier step
  logic [SEC_W-1:0] pp;

  assign pp = (mplr_q[0] ? mcand_q : '0) + (mplr_q[1] ? {mcand_q[SEC_W-2:0], 1'b0} : '0);

  // microsecond difference, sign and magnitude for the truncating divide
  logic [USEC_W:0] dus;
  logic [USEC_W:0] dus_mag;

  assign dus     = {1'b0, in_i.now_usec} - {1'b0, start_usec_q};
  assign dus_mag = dus[USEC_W] ? (~dus + (USEC_W+1)'(1)) : dus;

  // signed quotient of the microsecond difference
  logic [SEC_W-1:0] q_signed;

  assign q_signed = neg_q ? ('0 - dv_q) : dv_q;

  // due frame checks
  logic [SEC_W-1:0] fdiff;
  logic             rebase;
  logic             new_frame;

  assign fdiff     = dv_q - frames_q;
  assign rebase    = (dv_q < frames_q) || (fdiff > MAX_MISSED);
  assign new_frame = (dv_q != frames_q);

  // rebase shift split into seconds and microseconds
  logic              s_sub;
  logic [USEC_W-1:0] u_sub;
  logic              borrow;
  logic [SEC_W-1:0]  rb_sec;
  logic [USEC_W-1:0] rb_usec;

  assign s_sub   = (acc_q >= {{(SEC_W-USEC_W){1'b0}}, USEC_PER_SEC});
  assign u_sub   = s_sub ? '0 : acc_q[USEC_W-1:0];
  assign borrow  = (usec_q < u_sub);
  assign rb_sec  = sec_q - SEC_W'(s_sub) - SEC_W'(borrow);
  assign rb_usec = borrow ? (usec_q + USEC_PER_SEC - u_sub) : (usec_q - u_sub);

  // wait time, saturated
  logic [SEC_W-1:0]  wdiff;
  logic [WAIT_W-1:0] wait_sat;

  assign wdiff = dv_q - el_q;

  always_comb begin
    if (wdiff[SEC_W-1]) begin
      wait_sat = '0;
    end else if (wdiff > {{(SEC_W-WAIT_W){1'b0}}, WAIT_MAX}) begin
      wait_sat = WAIT_MAX;
    end else begin
      wait_sat = wdiff[WAIT_W-1:0];
    end
  end

  // sequencer and serial datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      fps_q        <= FPS_RESET;
      start_sec_q  <= '0;
      start_usec_q <= '0;
      frames_q     <= '0;
      sec_q        <= '0;
      usec_q       <= '0;
      neg_q        <= 1'b0;
      el_q         <= '0;
      res_due_q    <= 1'b0;
      res_wait_q   <= '0;
      out_valid_q  <= 1'b0;
      out_due_q    <= 1'b0;
      out_wait_q   <= '0;
      dv_q         <= '0;
      rem_q        <= '0;
      dvsr_q       <= '0;
      acc_q        <= '0;
      mcand_q      <= '0;
      mplr_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        fps_q <= cfg_wdata_i;
      end

      // result word is loaded or leaves
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // unit steps run while the counter is non-zero
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 6'd1;
        dv_q  <= {dv_q[SEC_W-2:0], q_bit};
        rem_q <= rem_nx;
        acc_q   <= acc_q + pp;
        mcand_q <= {mcand_q[SEC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        mplr_q  <= {{DIGIT_W{1'b0}}, mplr_q[FPS_W-1:DIGIT_W]};
      end else begin
        case (state_q)
          ST_IDLE: begin
            if (in_acc) begin
              res_due_q  <= 1'b0;
              res_wait_q <= '0;
              state_q    <= ST_DONE;
              case (in_i.action)
                ACT_START: begin
                  start_sec_q  <= in_i.now_sec;
                  start_usec_q <= in_i.now_usec;
                  frames_q     <= '0;
                end
                ACT_PREPARE: begin
                  sec_q   <= in_i.now_sec;
                  usec_q  <= in_i.now_usec;
                  neg_q   <= dus[USEC_W];
                  dv_q    <= {dus_mag[USEC_W-1:0], {(SEC_W-USEC_W){1'b0}}};
                  rem_q   <= '0;
                  dvsr_q  <= MS_PER_SEC;
                  cnt_q   <= DUS_STEPS;
                  state_q <= ST_DUS_DV;
                end
                ACT_DISPATCH: begin
                  if (in_i.handler_ok) begin
                    frames_q  <= frames_q + SEC_W'(1);
                    res_due_q <= 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
          end
          ST_DUS_DV: begin
            // elapsed = dsec * 1000 + signed quotient
            acc_q   <= q_signed;
            mcand_q <= sec_q - start_sec_q;
            mplr_q  <= MS_PER_SEC;
            cnt_q   <= MUL_STEPS;
            state_q <= ST_EL_MUL;
          end
          ST_EL_MUL: begin
            el_q    <= acc_q;
            mcand_q <= acc_q;
            acc_q   <= '0;
            mplr_q  <= rate;
            cnt_q   <= MUL_STEPS;
            state_q <= ST_FN_MUL;
          end
          ST_FN_MUL: begin
            dv_q    <= acc_q;
            rem_q   <= '0;
            dvsr_q  <= MS_PER_SEC;
            cnt_q   <= DIV_STEPS;
            state_q <= ST_FN_DV;
          end
          ST_FN_DV: begin
            if (rebase) begin
              // frame period rounded up to whole ms
              dv_q    <= {({1'b0, rate} + FT_W'(MS_PER_SEC) - FT_W'(1)),
                          {(SEC_W-FT_W){1'b0}}};
              rem_q   <= '0;
              dvsr_q  <= rate;
              cnt_q   <= FT_STEPS;
              state_q <= ST_FT_DV;
            end else if (new_frame) begin
              res_due_q <= 1'b1;
              state_q   <= ST_DONE;
            end else begin
              acc_q   <= '0;
              mcand_q <= frames_q + SEC_W'(1);
              mplr_q  <= MS_PER_SEC;
              cnt_q   <= MUL_STEPS;
              state_q <= ST_TG_MUL;
            end
          end
          ST_FT_DV: begin
            acc_q   <= '0;
            mcand_q <= dv_q;
            mplr_q  <= MS_PER_SEC;
            cnt_q   <= MUL_STEPS;
            state_q <= ST_SH_MUL;
          end
          ST_SH_MUL: begin
            // move the start one frame before now
            if (usec_q < USEC_PER_SEC) begin
              start_sec_q  <= rb_sec;
              start_usec_q <= rb_usec;
            end else begin
              start_sec_q  <= sec_q;
              start_usec_q <= usec_q;
            end
            frames_q  <= '0;
            res_due_q <= 1'b1;
            state_q   <= ST_DONE;
          end
          ST_TG_MUL: begin
            dv_q    <= acc_q;
            rem_q   <= '0;
            dvsr_q  <= rate;
            cnt_q   <= DIV_STEPS;
            state_q <= ST_TG_DV;
          end
          ST_TG_DV: begin
            res_wait_q <= wait_sat;
            state_q    <= ST_DONE;
          end
          ST_DONE: begin
            if (out_free) begin
              out_due_q   <= res_due_q;
              out_wait_q  <= res_wait_q;
              state_q     <= ST_IDLE;
            end
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame interval pacer. Words go in through the
// input channel with random gaps and come back through the result channel
// under random stalls. Each accepted word runs through a local pacing model,
// and every result is compared against it field by field. The run covers
// directed corner cases, a sweep of frame rates and random pacing sessions.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fip_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int STALL_MAX    = 14;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int END_WAIT     = 150;
  localparam int REPORT_MAX   = 10;
  localparam int US_PER_S     = int'(USEC_PER_SEC);

  typedef struct packed {
    logic              frame_due;
    logic [WAIT_W-1:0] wait_ms;
  } pace_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [FPS_W-1:0] cfg_wdata;

  fip_in_if  in_if ();
  fip_out_if out_if ();

  frame_interval_pacer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // pacing model state
  logic [FPS_W-1:0]  fps_reg;
  logic [SEC_W-1:0]  base_sec;
  logic [USEC_W-1:0] base_usec;
  logic [31:0]       frames_done;
  pace_word_t        pacing_results[$];
  logic              last_due;

  // stimulus clock and idling controls
  logic [SEC_W-1:0] clock_sec;
  int               clock_usec;
  bit               sender_gaps     = 1'b1;
  bit               receiver_stalls = 1'b1;
  int               receiver_hold   = 0;

  // tallies
  int failures      = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int rate_settings = 0;
  int due_count     = 0;
  int wait_count    = 0;
  int rebase_count  = 0;
  int long_holds    = 0;
  int idle_cycles   = 0;

  always #CLK_HALF clk_i = ~clk_i;

  // pacing model: one word in, expected result out, state updated
  function automatic pace_word_t pace_frame(input logic [ACTION_W-1:0] act,
                                            input logic [SEC_W-1:0] sec,
                                            input logic [USEC_W-1:0] usec,
                                            input logic ok);
    logic [31:0] rate, el, fnum, step_us, sec_sub, usec_sub, target, diff;
    int          usec_diff;
    pace_word_t  res;
    res  = '0;
    rate = (fps_reg == '0) ? 32'd1 : 32'(fps_reg);
    case (act)
      ACT_START: begin
        base_sec    = sec;
        base_usec   = usec;
        frames_done = '0;
      end
      ACT_PREPARE: begin
        // elapsed ms, sub-second part truncated toward zero
        usec_diff = int'(32'(usec)) - int'(32'(base_usec));
        el   = (sec - base_sec) * 32'(MS_PER_SEC) + 32'(usec_diff / int'(MS_PER_SEC));
        fnum = (el * rate) / 32'(MS_PER_SEC);
        if (fnum < frames_done || fnum - frames_done > 32'(MAX_MISSED)) begin
          // rebase one rounded-up frame period before now
          step_us   = ((32'(MS_PER_SEC) + rate - 32'd1) / rate) * 32'(MS_PER_SEC);
          base_sec  = sec;
          base_usec = usec;
          if (usec < USEC_PER_SEC) begin
            sec_sub  = step_us / 32'(USEC_PER_SEC);
            usec_sub = step_us % 32'(USEC_PER_SEC);
            base_sec = sec - sec_sub;
            if (32'(usec) < usec_sub) begin
              base_usec = USEC_W'(32'(usec) + 32'(USEC_PER_SEC) - usec_sub);
              base_sec  = base_sec - 32'd1;
            end else begin
              base_usec = USEC_W'(32'(usec) - usec_sub);
            end
          end
          frames_done   = '0;
          res.frame_due = 1'b1;
          rebase_count++;
        end else if (fnum > frames_done) begin
          res.frame_due = 1'b1;
          due_count++;
        end else begin
          // time to next frame, clamped to the wait range
          target = ((frames_done + 32'd1) * 32'(MS_PER_SEC)) / rate;
          diff   = target - el;
          if (diff[31]) begin
            res.wait_ms = '0;
          end else if (diff > 32'(WAIT_MAX)) begin
            res.wait_ms = WAIT_MAX;
          end else begin
            res.wait_ms = diff[WAIT_W-1:0];
          end
          wait_count++;
        end
      end
      ACT_DISPATCH: begin
        if (ok) begin
          frames_done   = frames_done + 32'd1;
          res.frame_due = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("mismatch: %s", msg);
  endfunction

  // moves the stimulus clock by a signed number of microseconds
  function automatic void advance_clock(input int delta_us);
    int total;
    total = clock_usec + delta_us;
    while (total < 0) begin
      total += US_PER_S;
      clock_sec = clock_sec - 32'd1;
    end
    while (total >= US_PER_S) begin
      total -= US_PER_S;
      clock_sec = clock_sec + 32'd1;
    end
    clock_usec = total;
  endfunction

  // offer one word, predict its result once it is taken
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [SEC_W-1:0] sec,
                           input logic [USEC_W-1:0] usec, input logic ok);
    int gap;
    pace_word_t res;
    gap = sender_gaps ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.now_sec    <= sec;
    in_if.now_usec   <= usec;
    in_if.handler_ok <= ok;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    res      = pace_frame(act, sec, usec, ok);
    last_due = res.frame_due;
    pacing_results.push_back(res);
    words_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pacing_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [FPS_W-1:0] fps);
    cfg_we    <= 1'b1;
    cfg_wdata <= fps;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    fps_reg  = fps;
    rate_settings++;
  endtask

  function automatic logic [ACTION_W-1:0] ACT_ACTION_RAND();
    return ACTION_W'($urandom_range(0, 3));
  endfunction

  // one pacing session: start, then prepare/dispatch cycles with some noise
  task automatic run_session(input int n_words);
    int                  frame_us, roll, delta;
    bit                  frame_ready;
    logic [ACTION_W-1:0] act;
    logic [SEC_W-1:0]    sec;
    logic [USEC_W-1:0]   usec;
    logic                ok;
    frame_us   = US_PER_S / ((fps_reg == '0) ? 1 : int'(fps_reg));
    clock_sec  = $urandom;
    clock_usec = $urandom_range(0, US_PER_S - 1);
    send_word(ACT_START, clock_sec, USEC_W'(clock_usec), 1'($urandom_range(0, 1)));
    frame_ready = 1'b0;
    repeat (n_words) begin
      roll = $urandom_range(0, 99);
      act  = ACT_PREPARE;
      ok   = 1'($urandom_range(0, 1));
      if (roll < 4) begin
        // arbitrary word, any code, microseconds possibly past a second
        act = ACT_ACTION_RAND();
      end else if (roll < 8) begin
        // clock steps back
        delta = $urandom_range(1, 3 * frame_us);
        advance_clock(-delta);
      end else if (roll < 12) begin
        // long gap, several frames missed
        advance_clock($urandom_range(3 * frame_us, 20 * frame_us));
      end else if (roll < 14) begin
        act = ACT_START;
      end else if (frame_ready) begin
        act = ACT_DISPATCH;
        ok  = ($urandom_range(0, 9) != 0);
      end else begin
        advance_clock($urandom_range(0, frame_us + frame_us / 2));
      end
      sec  = clock_sec;
      usec = USEC_W'(clock_usec);
      if (roll < 4) begin
        sec  = $urandom;
        usec = USEC_W'($urandom_range(0, 2**USEC_W - 1));
      end
      send_word(act, sec, usec, ok);
      frame_ready = (act == ACT_PREPARE) && last_due;
    end
  endtask

  // corner words at the reset rate
  task automatic test_directed();
    settle();
    send_word(ACT_PREPARE,  32'd0, 20'd0, 1'b0);
    send_word(ACT_START,    32'd0, 20'd0, 1'b1);
    send_word(ACT_PREPARE,  32'd0, 20'd10000, 1'b0);
    send_word(ACT_PREPARE,  32'd0, 20'd17000, 1'b0);
    send_word(ACT_DISPATCH, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
    send_word(ACT_DISPATCH, 32'd0, 20'd0, 1'b0);
    send_word(ACT_PREPARE,  32'd0, 20'd50000, 1'b0);
    // time goes backwards, rebase borrows below second zero
    send_word(ACT_PREPARE,  32'd0, 20'd0, 1'b0);
    send_word(ACT_UNUSED,   32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
    send_word(ACT_START,    32'hFFFF_FFFF, 20'd999999, 1'b0);
    // seconds wrap between start and prepare
    send_word(ACT_PREPARE,  32'd0, 20'd5000, 1'b0);
    send_word(ACT_DISPATCH, 32'd0, 20'd0, 1'b1);
    send_word(ACT_PREPARE,  32'd1, 20'd0, 1'b0);
    // microseconds out of range
    send_word(ACT_START,    32'd5, 20'hFFFFF, 1'b0);
    send_word(ACT_PREPARE,  32'd5, 20'hFFFFF, 1'b0);
    send_word(ACT_PREPARE,  32'd4, 20'hFFFFF, 1'b0);
    send_word(ACT_PREPARE,  32'hAAAA_AAAA, 20'h55555, 1'b0);
    send_word(ACT_START,    32'h5555_5555, 20'hAAAAA, 1'b1);
    // wait lands exactly on zero without a frame due
    send_word(ACT_PREPARE,  32'h5555_5555, 20'd715050, 1'b0);
    send_word(ACT_DISPATCH, 32'h1234_5678, 20'h5A5A5, 1'b0);
    send_word(ACT_UNUSED,   32'd0, 20'd0, 1'b0);
  endtask

  // short sessions across the rate range, zero and over-range included
  task automatic test_rates();
    logic [FPS_W-1:0] sweep [8];
    sweep = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd7, 10'd60, 10'd999, 10'd512};
    foreach (sweep[i]) begin
      settle();
      write_rate(sweep[i]);
      run_session(12);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    settle();
    sender_gaps   = 1'b0;
    receiver_hold = LONG_HOLD;
    run_session(14);
    settle();
    sender_gaps = 1'b1;
  endtask

  // random sessions, random rates, each idling mix in turn
  task automatic test_random();
    int goal;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      sender_gaps     = (phase & 1) == 0;
      receiver_stalls = (phase & 2) == 0;
      if ($urandom_range(0, 99) < 15) begin
        write_rate(FPS_W'($urandom_range(0, 2**FPS_W - 1)));
      end else begin
        write_rate(FPS_W'($urandom_range(1, 1000)));
      end
      goal = words_sent + 180;
      while (words_sent < goal) run_session($urandom_range(10, 60));
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // result side: random stalls, long hold on request, compare each word
  initial begin : result_monitor
    int         stall;
    pace_word_t exp_word;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = receiver_stalls ? $urandom_range(0, STALL_MAX) : 0;
      if (receiver_hold > 0) begin
        stall         = receiver_hold;
        receiver_hold = 0;
        long_holds++;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      results_seen++;
      if (pacing_results.size() == 0) begin
        note_failure($sformatf("unexpected word: due %0b wait %0d",
                               out_if.frame_due, out_if.wait_ms));
      end else begin
        exp_word = pacing_results.pop_front();
        if (out_if.frame_due !== exp_word.frame_due || out_if.wait_ms !== exp_word.wait_ms) begin
          note_failure($sformatf("result %0d: expected due %0b wait %0d, got due %0b wait %0d",
                                 results_seen, exp_word.frame_due, exp_word.wait_ms,
                                 out_if.frame_due, out_if.wait_ms));
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("** frame_interval_pacer: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= FPS_RESET;
    in_if.valid      <= 1'b0;
    in_if.action     <= ACT_START;
    in_if.now_sec    <= '0;
    in_if.now_usec   <= '0;
    in_if.handler_ok <= 1'b0;
    fps_reg     = FPS_RESET;
    base_sec    = '0;
    base_usec   = '0;
    frames_done = '0;
    last_due    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_rates();
    test_backpressure();
    test_random();

    settle();
    repeat (END_WAIT) @(posedge clk_i);
    if (pacing_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pacing_results.size()));
    end
    $display("covered %0d words in, %0d results checked, %0d rate settings, %0d long holds",
             words_sent, results_seen, rate_settings, long_holds);
    $display("prepare outcomes: %0d frames due, %0d waits, %0d rebases; %0d failures",
             due_count, wait_count, rebase_count, failures);
    if (failures == 0) begin
      $display("** frame_interval_pacer: PASSED **");
    end else begin
      $display("** frame_interval_pacer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/fip_pkg.sv
hdl/fip_in_if.sv
hdl/fip_out_if.sv
hdl/frame_interval_pacer.sv
tb/tb_top.sv
